/* rtl/core/csi_escape_parser_with_cursor_report_macros.svh */
// Assertion helpers for the escape parser block.
// Each macro takes a label, clock, active-low reset, trigger, check and message.
`ifndef CSI_ESCAPE_PARSER_WITH_CURSOR_REPORT_MACROS_SVH
`define CSI_ESCAPE_PARSER_WITH_CURSOR_REPORT_MACROS_SVH

`ifndef SYNTHESIS
`define CERP_ASSERT_SAME(lbl, ck, rn, trig, chk, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |-> (chk)) \
		else $error(msg);
`define CERP_ASSERT_NEXT(lbl, ck, rn, trig, chk, msg) \
	lbl: assert property (@(posedge ck) disable iff (!rn) (trig) |=> (chk)) \
		else $error(msg);
`else
`define CERP_ASSERT_SAME(lbl, ck, rn, trig, chk, msg)
`define CERP_ASSERT_NEXT(lbl, ck, rn, trig, chk, msg)
`endif

`endif

/* rtl/core/cerp_pkg.sv */
`default_nettype none
package cerp_pkg;

	localparam int ADDR_W = 3;
	localparam int COLS_W = 10;
	localparam logic [COLS_W-1:0] COLS_RESET = 10'd80;
	localparam logic ADDR_COLUMNS = 1'b0; // paddr[2] of the columns register

	localparam logic [1:0] FN_WRITE = 2'd0;
	localparam logic [1:0] FN_READ  = 2'd1;
	localparam logic [1:0] FN_SET   = 2'd2;

	localparam logic [7:0] CH_ESC  = 8'h1B;
	localparam logic [7:0] CH_LBRK = 8'h5B;
	localparam logic [7:0] CH_LS   = 8'h73;
	localparam logic [7:0] CH_LU   = 8'h75;
	localparam logic [7:0] CH_QM   = 8'h3F;
	localparam logic [7:0] CH_SEMI = 8'h3B;
	localparam logic [7:0] CH_UH   = 8'h48;
	localparam logic [7:0] CH_UR   = 8'h52;
	localparam logic [7:0] CH_LI   = 8'h69;
	localparam logic [7:0] CH_LN   = 8'h6E;
	localparam logic [7:0] CH_LH   = 8'h68;
	localparam logic [7:0] CH_LL   = 8'h6C;
	localparam logic [7:0] CH_UA   = 8'h41;
	localparam logic [7:0] CH_UG   = 8'h47;
	localparam logic [7:0] CH_UJ   = 8'h4A;
	localparam logic [7:0] CH_UK   = 8'h4B;
	localparam logic [7:0] CH_US   = 8'h53;
	localparam logic [7:0] CH_UT   = 8'h54;
	localparam logic [7:0] CH_LF   = 8'h66;
	localparam logic [7:0] CH_LM   = 8'h6D;
	localparam logic [7:0] CH_0    = 8'h30;
	localparam logic [7:0] CH_2    = 8'h32;
	localparam logic [7:0] CH_4    = 8'h34;
	localparam logic [7:0] CH_5    = 8'h35;
	localparam logic [7:0] CH_6    = 8'h36;
	localparam logic [7:0] CH_9    = 8'h39;

	typedef enum logic [3:0] {
		PS_IDLE, PS_ESC, PS_BR, PS_NUM, PS_N4, PS_N5, PS_N6, PS_SEMI, PS_M, PS_Q
	} ps_t;

	typedef enum logic [2:0] {
		RP_NONE, RP_ESC, RP_BR, RP_ROW, RP_COL
	} rp_t;

	typedef enum logic [2:0] {
		ST_IDLE, ST_EXEC, ST_MUL, ST_DIV, ST_CINIT, ST_CONV, ST_PICK, ST_EMIT
	} st_t;

	typedef struct packed {
		logic [1:0]  func;
		logic [7:0]  byte_req;
		logic [15:0] position;
	} req_t;

	typedef struct packed {
		logic        consumed;
		logic        report_valid;
		logic [7:0]  report_byte;
		logic [15:0] cursor;
		logic        cursor_hidden;
		logic        aux_on;
	} rsp_t;

	typedef struct packed {
		logic cap;
		logic exec;
		logic mul;
		logic div_init;
		logic div_step;
		logic conv_init;
		logic conv_step;
		logic pick;
		logic emit;
	} cmd_t;

	typedef struct packed {
		logic need_mul;
		logic need_rep;
	} stat_t;

endpackage
`default_nettype wire

/* rtl/core/cerp_if.sv */
`default_nettype none
interface cerp_req_if;
	logic valid;
	logic ready;
	cerp_pkg::req_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface

interface cerp_rsp_if;
	logic valid;
	logic ready;
	cerp_pkg::rsp_t data;
	modport source (output valid, output data, input ready);
	modport sink (input valid, input data, output ready);
endinterface
`default_nettype wire

/* rtl/core/csi_escape_parser_with_cursor_report.sv */
// ANSI CSI escape parser with cursor position report.
// req_ch carries one request: func 0 writes a byte to the parser, func 1 reads
// the next byte of a pending cursor report (ESC [ row ; col R), func 2 sets the
// linear cursor. rsp_ch returns exactly one response per request with the
// consumed flag, the report byte and the cursor/hidden/aux state after it.
// Requests are handled one at a time (req_ch.ready is high only when the
// controller is idle). Each request is captured, executed and emitted:
//   write, set, idle read, ESC/'[' report bytes: execute, then emit
//   cursor move by H: one extra step for the row*columns multiply
//   row/column digit or separator: the bit-serial divider and the bit-serial
//   binary to decimal converter run before the report byte is picked.
// With rsp_ch free, the next request is taken in the cycle after the response
// is emitted.
// A finished response sits in an output register; the next request is taken
// while it waits, and the controller holds a second result until rsp_ch drains.
// The columns register lives on the APB port (address 0, reset 80; 0 acts
// as 1). Reset clears the parser, cursor, saved cursor, flags and any report.
`default_nettype none
`include "csi_escape_parser_with_cursor_report_macros.svh"
module csi_escape_parser_with_cursor_report #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	cerp_req_if.sink                           req_ch,
	cerp_rsp_if.source                         rsp_ch,
	input  wire logic                          psel,
	input  wire logic                          penable,
	input  wire logic                          pwrite,
	input  wire logic [cerp_pkg::ADDR_W-1:0]   paddr,
	input  wire logic [31:0]                   pwdata,
	output logic [31:0]                        prdata,
	output logic                               pready
);
	import cerp_pkg::*;

	logic [COLS_W-1:0] columns_q;
	logic [COLS_W-1:0] cols_eff;
	cmd_t cmd;
	stat_t stat;
	rsp_t res;
	logic out_free;
	logic out_valid_q;
	rsp_t out_data_q;

	// config port: zero wait states, word decode on paddr[2]
	assign pready = 1'b1;
	assign prdata = (paddr[2] == ADDR_COLUMNS) ? {22'd0, columns_q} : 32'd0;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) columns_q <= COLS_RESET;
		else if (psel && penable && pwrite && paddr[2] == ADDR_COLUMNS)
			columns_q <= pwdata[COLS_W-1:0];
	end

	assign cols_eff = (columns_q == '0) ? COLS_W'(1) : columns_q;

	// output register frees up the same cycle the consumer takes it
	assign out_free = !out_valid_q || rsp_ch.ready;

	cerp_ctrl #(.POSITION_BITS(POSITION_BITS)) u_ctrl (
		.clk(clk),
		.arst_n(arst_n),
		.req_valid(req_ch.valid),
		.req_ready(req_ch.ready),
		.out_free(out_free),
		.stat(stat),
		.cmd(cmd)
	);

	cerp_dp #(.POSITION_BITS(POSITION_BITS)) u_dp (
		.clk(clk),
		.arst_n(arst_n),
		.cmd(cmd),
		.req(req_ch.data),
		.cols(cols_eff),
		.stat(stat),
		.res(res)
	);

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) out_valid_q <= 1'b0;
		else if (cmd.emit) out_valid_q <= 1'b1;
		else if (rsp_ch.ready) out_valid_q <= 1'b0;
	end

	always_ff @(posedge clk) begin
		if (cmd.emit) out_data_q <= res;
	end

	assign rsp_ch.valid = out_valid_q;
	assign rsp_ch.data = out_data_q;

	`CERP_ASSERT_NEXT(a_one_at_a_time, clk, arst_n, req_ch.valid && req_ch.ready, !req_ch.ready, "request accepted while busy")
	`CERP_ASSERT_SAME(a_byte_zero, clk, arst_n, rsp_ch.valid && !rsp_ch.data.report_valid, rsp_ch.data.report_byte == 8'd0, "report byte without valid")
	`CERP_ASSERT_SAME(a_cons_xor_rep, clk, arst_n, rsp_ch.valid && rsp_ch.data.consumed, !rsp_ch.data.report_valid, "consumed and report together")
	`CERP_ASSERT_SAME(a_emit_free, clk, arst_n, cmd.emit, !out_valid_q || rsp_ch.ready, "response overwritten")

endmodule
`default_nettype wire

/* rtl/core/cerp_ctrl.sv */
`default_nettype none
module cerp_ctrl #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic           clk,
	input  wire logic           arst_n,
	input  wire logic           req_valid,
	output logic                req_ready,
	input  wire logic           out_free,
	input  wire cerp_pkg::stat_t stat,
	output cerp_pkg::cmd_t      cmd
);
	import cerp_pkg::*;

	localparam int CW = $clog2(POSITION_BITS + 2);

	st_t state_q, state_n;
	logic [CW-1:0] cnt_q;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= ST_IDLE;
			cnt_q   <= '0;
		end else begin
			state_q <= state_n;
			case (state_q)
				ST_EXEC:  cnt_q <= CW'(POSITION_BITS);
				ST_CINIT: cnt_q <= CW'(POSITION_BITS + 1);
				ST_DIV, ST_CONV: cnt_q <= cnt_q - 1'b1;
				default: cnt_q <= cnt_q;
			endcase
		end
	end

	always_comb begin
		state_n = state_q;
		case (state_q)
			ST_IDLE: if (req_valid) state_n = ST_EXEC;
			ST_EXEC: begin
				if (stat.need_mul) state_n = ST_MUL;
				else if (stat.need_rep) state_n = ST_DIV;
				else state_n = ST_EMIT;
			end
			ST_MUL: state_n = ST_EMIT;
			ST_DIV: if (cnt_q == CW'(1)) state_n = ST_CINIT;
			ST_CINIT: state_n = ST_CONV;
			ST_CONV: if (cnt_q == CW'(1)) state_n = ST_PICK;
			ST_PICK: state_n = ST_EMIT;
			ST_EMIT: if (out_free) state_n = ST_IDLE;
			default: state_n = ST_IDLE;
		endcase
	end

	always_comb begin
		cmd = '0;
		req_ready = 1'b0;
		case (state_q)
			ST_IDLE: begin
				req_ready = 1'b1;
				cmd.cap = req_valid;
			end
			ST_EXEC: begin
				cmd.exec = 1'b1;
				cmd.div_init = stat.need_rep && !stat.need_mul;
			end
			ST_MUL: cmd.mul = 1'b1;
			ST_DIV: cmd.div_step = 1'b1;
			ST_CINIT: cmd.conv_init = 1'b1;
			ST_CONV: cmd.conv_step = 1'b1;
			ST_PICK: cmd.pick = 1'b1;
			ST_EMIT: cmd.emit = out_free;
			default: cmd = '0;
		endcase
	end

endmodule
`default_nettype wire

/* rtl/core/cerp_dp.sv */
`default_nettype none
module cerp_dp #(
	parameter int POSITION_BITS = 16
) (
	input  wire logic                          clk,
	input  wire logic                          arst_n,
	input  wire cerp_pkg::cmd_t                cmd,
	input  wire cerp_pkg::req_t                req,
	input  wire logic [cerp_pkg::COLS_W-1:0]   cols,
	output cerp_pkg::stat_t                    stat,
	output cerp_pkg::rsp_t                     res
);
	import cerp_pkg::*;

	localparam int PB = POSITION_BITS;
	localparam int VW = PB + 1;
	localparam int NDIG = (VW * 30103) / 100000 + 1;
	localparam int KW = $clog2(NDIG + 1);
	localparam logic [32:0] PosMax = (33'd1 << PB) - 33'd1;

	function automatic logic [15:0] acc_digit(input logic [15:0] v, input logic [7:0] b);
		logic [19:0] r;
		r = 20'(v) * 20'd10 + 20'(b - CH_0);
		return (r > 20'd65535) ? 16'hFFFF : r[15:0];
	endfunction

	function automatic logic is_keep(input logic [7:0] b);
		return (b >= CH_UA && b <= CH_UG) || b == CH_UJ || b == CH_UK || b == CH_US ||
			b == CH_UT || b == CH_LF || b == CH_LM;
	endfunction

	// item and architectural state
	req_t item_q;
	ps_t ps_q, ps_n;
	logic [15:0] fp_q, fp_n, sp_q, sp_n;
	logic [PB-1:0] cur_q, saved_q;
	logic hid_q, hid_n, aux_q, aux_n;
	rp_t rp_q;
	logic [KW-1:0] k_q;
	// result
	logic consumed_q, rvalid_q;
	logic [7:0] rbyte_q;
	// arithmetic
	logic [25:0] prod_q;
	logic [15:0] addc_q;
	logic [PB-1:0] quo_q;
	logic [COLS_W-1:0] rem_q;
	logic [VW-1:0] bin_q;
	logic [3:0] bcd_q [NDIG];

	logic cons, do_save, do_rest, rep_start, h_hit, fin, is_dig, in_fin;
	logic [7:0] b;
	logic [15:0] r_h, c_h;
	logic [26:0] hsum;
	logic [COLS_W:0] dt;
	logic dge;
	logic [3:0] adj [NDIG];
	logic [KW-1:0] ndig, idx;
	logic [3:0] dsel;

	assign b = item_q.byte_req;
	assign r_h = (fp_q != 16'd0) ? fp_q - 16'd1 : 16'd0;
	assign c_h = (sp_q != 16'd0) ? sp_q - 16'd1 : 16'd0;
	assign hsum = 27'(prod_q) + 27'(addc_q);
	assign dt = {rem_q, quo_q[PB-1]};
	assign dge = dt >= {1'b0, cols};

	always_comb begin
		ps_n = ps_q; fp_n = fp_q; sp_n = sp_q; hid_n = hid_q; aux_n = aux_q;
		cons = 1'b0; do_save = 1'b0; do_rest = 1'b0; rep_start = 1'b0;
		h_hit = 1'b0; fin = 1'b0;
		is_dig = b >= CH_0 && b <= CH_9;
		in_fin = b >= CH_UA && b <= CH_LM;
		if (b == CH_ESC && ps_q == PS_IDLE) begin
			ps_n = PS_ESC; cons = 1'b1;
		end else if (b == CH_LBRK && ps_q == PS_ESC) begin
			ps_n = PS_BR; fp_n = '0; sp_n = '0; cons = 1'b1;
		end else begin
			case (ps_q)
				PS_IDLE, PS_ESC: cons = 1'b0;
				PS_BR: begin
					if (b == CH_LS) begin
						do_save = 1'b1; cons = 1'b1;
					end else if (b == CH_LU) begin
						do_rest = 1'b1; cons = 1'b1;
					end else if (b == CH_QM) begin
						ps_n = PS_Q; cons = 1'b1;
					end else if (b == CH_SEMI) begin
						ps_n = PS_SEMI; fp_n = 16'd1; cons = 1'b1;
					end else if (is_dig) begin
						if (b == CH_4) ps_n = PS_N4;
						else if (b == CH_5) ps_n = PS_N5;
						else if (b == CH_6) ps_n = PS_N6;
						else ps_n = PS_NUM;
						fp_n = 16'(b - CH_0);
						cons = 1'b1;
					end
				end
				PS_NUM, PS_N4, PS_N5, PS_N6: begin
					if ((ps_q == PS_N4 || ps_q == PS_N5) && b == CH_LI) begin
						aux_n = ps_q == PS_N5; ps_n = PS_IDLE; cons = 1'b1;
					end else if (ps_q == PS_N6 && b == CH_LN) begin
						ps_n = PS_IDLE; rep_start = 1'b1; cons = 1'b1;
					end else begin
						ps_n = PS_NUM;
						if (b == CH_SEMI) begin
							ps_n = PS_M; cons = 1'b1;
						end else if (in_fin) begin
							fin = 1'b1;
						end else if (is_dig) begin
							fp_n = acc_digit(fp_q, b); cons = 1'b1;
						end else begin
							ps_n = PS_IDLE; fp_n = '0; sp_n = '0;
						end
					end
				end
				PS_SEMI, PS_M: begin
					if (in_fin) begin
						fin = 1'b1;
					end else if (is_dig) begin
						sp_n = acc_digit(sp_q, b); cons = 1'b1;
					end else begin
						ps_n = PS_IDLE; fp_n = '0; sp_n = '0;
					end
				end
				PS_Q: begin
					if (b == CH_LL || b == CH_LH) begin
						fin = 1'b1;
					end else if (b == CH_2 || b == CH_5) begin
						cons = 1'b1;
					end else begin
						ps_n = PS_IDLE; fp_n = '0; sp_n = '0;
					end
				end
				default: ps_n = PS_IDLE;
			endcase
			// final: is_keep finals leave the sequence as is, others end it
			if (fin && !is_keep(b)) begin
				ps_n = PS_IDLE; fp_n = '0; sp_n = '0;
				if (b == CH_UH) begin
					h_hit = 1'b1; cons = 1'b1;
				end else if (b == CH_LH) begin
					hid_n = 1'b0; cons = 1'b1;
				end else if (b == CH_LL) begin
					hid_n = 1'b1; cons = 1'b1;
				end
			end
		end
	end

	assign stat.need_mul = item_q.func == FN_WRITE && h_hit;
	assign stat.need_rep = item_q.func == FN_READ && (rp_q == RP_ROW || rp_q == RP_COL);

	// digit count and digit select for the report
	always_comb begin
		ndig = '0;
		dsel = '0;
		for (int i = 0; i < NDIG; i++) begin
			if (bcd_q[i] != 4'd0) ndig = KW'(i + 1);
			adj[i] = (bcd_q[i] >= 4'd5) ? bcd_q[i] + 4'd3 : bcd_q[i];
		end
		idx = ndig - k_q - KW'(1);
		for (int i = 0; i < NDIG; i++) begin
			if (idx == KW'(i)) dsel = bcd_q[i];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			ps_q <= PS_IDLE;
			fp_q <= '0;
			sp_q <= '0;
			cur_q <= '0;
			saved_q <= '0;
			hid_q <= 1'b0;
			aux_q <= 1'b0;
			rp_q <= RP_NONE;
			k_q <= '0;
		end else begin
			if (cmd.exec) begin
				case (item_q.func)
					FN_WRITE: begin
						ps_q <= ps_n; fp_q <= fp_n; sp_q <= sp_n;
						hid_q <= hid_n; aux_q <= aux_n;
						if (do_save) saved_q <= cur_q;
						if (do_rest) cur_q <= saved_q;
						if (rep_start) rp_q <= RP_ESC;
					end
					FN_READ: begin
						if (rp_q == RP_ESC) rp_q <= RP_BR;
						else if (rp_q == RP_BR) begin
							rp_q <= RP_ROW; k_q <= '0;
						end
					end
					FN_SET: begin
						cur_q <= ({17'd0, item_q.position} > PosMax) ? PosMax[PB-1:0]
							: PB'(item_q.position);
					end
					default: cur_q <= cur_q;
				endcase
			end
			if (cmd.mul) cur_q <= (33'(hsum) > PosMax) ? PosMax[PB-1:0] : PB'(hsum);
			if (cmd.pick) begin
				if (ndig <= k_q) begin
					if (rp_q == RP_ROW) rp_q <= RP_COL;
					else rp_q <= RP_NONE;
					k_q <= '0;
				end else begin
					k_q <= k_q + KW'(1);
				end
			end
		end
	end

	always_ff @(posedge clk) begin
		if (cmd.cap) item_q <= req;
		if (cmd.exec) begin
			consumed_q <= item_q.func == FN_WRITE && cons;
			rvalid_q <= item_q.func == FN_READ && rp_q != RP_NONE;
			rbyte_q <= '0;
			if (item_q.func == FN_READ && rp_q == RP_ESC) rbyte_q <= CH_ESC;
			if (item_q.func == FN_READ && rp_q == RP_BR) rbyte_q <= CH_LBRK;
			prod_q <= 26'(r_h) * 26'(cols);
			addc_q <= c_h;
		end
		if (cmd.div_init) begin
			quo_q <= cur_q;
			rem_q <= '0;
		end
		if (cmd.div_step) begin
			quo_q <= {quo_q[PB-2:0], dge};
			rem_q <= dge ? COLS_W'(dt - {1'b0, cols}) : dt[COLS_W-1:0];
		end
		if (cmd.conv_init) begin
			bin_q <= ((rp_q == RP_ROW) ? {1'b0, quo_q} : VW'(rem_q)) + VW'(1);
			for (int i = 0; i < NDIG; i++) bcd_q[i] <= '0;
		end
		if (cmd.conv_step) begin
			bin_q <= {bin_q[VW-2:0], 1'b0};
			bcd_q[0] <= {adj[0][2:0], bin_q[VW-1]};
			for (int i = 1; i < NDIG; i++) bcd_q[i] <= {adj[i][2:0], adj[i-1][3]};
		end
		if (cmd.pick) begin
			if (ndig <= k_q) rbyte_q <= (rp_q == RP_ROW) ? CH_SEMI : CH_UR;
			else rbyte_q <= CH_0 | {4'd0, dsel};
		end
	end

	assign res.consumed = consumed_q;
	assign res.report_valid = rvalid_q;
	assign res.report_byte = rbyte_q;
	assign res.cursor = 16'(cur_q);
	assign res.cursor_hidden = hid_q;
	assign res.aux_on = aux_q;

endmodule
`default_nettype wire
